@@ rtl/lhbm_pkg.sv @@
// Package for the level history bar meter: widths, codes, bar tables and the
// structures passed between the configuration block, controller and datapath.
// Depends on nothing.
package lhbm_pkg;

    // Display geometry.
    localparam int BAR_COUNT_DEF = 15;
    localparam int DEPTH         = 15;
    localparam logic [3:0] LAST_BAR = 4'(DEPTH - 1);

    // Configuration register indexes.
    localparam logic [1:0] CFG_UPDATE_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_CENTER_LINE     = 2'd1;
    localparam logic [1:0] CFG_MIN_HEIGHT      = 2'd2;
    localparam logic [1:0] CFG_DEADBAND        = 2'd3;

    // Configuration reset values.
    localparam logic [19:0] RST_UPDATE_INTERVAL = 20'd66000;
    localparam logic [9:0]  RST_CENTER_LINE     = 10'd354;
    localparam logic [5:0]  RST_MIN_HEIGHT      = 6'd6;
    localparam logic [5:0]  RST_DEADBAND        = 6'd2;

    // Voice state codes.
    localparam logic [1:0] VS_HIDDEN    = 2'd0;
    localparam logic [1:0] VS_PREPARING = 2'd1;
    localparam logic [1:0] VS_LISTENING = 2'd2;
    localparam logic [1:0] VS_OTHER     = 2'd3;

    // Register file contents.
    typedef struct packed {
        logic [19:0] update_interval;
        logic [9:0]  center_line;
        logic [5:0]  min_height;
        logic [5:0]  deadband;
    } t_cfg;

    // Controller to datapath commands.
    typedef struct packed {
        logic       clear;  // hidden state: wipe history and update time
        logic       start;  // refresh begins: latch item, shift history when listening
        logic       step;   // evaluate the bar selected by bar
        logic       flush;  // hand the held result over as the final one
        logic [3:0] bar;
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic is_hidden;
        logic is_early;
        logic can_step;
        logic flush_ok;
    } t_status;

    // Peak height of each bar.
    function automatic logic [6:0] bar_peak(input logic [3:0] bar);
        logic [6:0] p;
        case (bar)
            4'd0, 4'd14: p = 7'd18;
            4'd1, 4'd13: p = 7'd22;
            4'd2, 4'd12: p = 7'd28;
            4'd3, 4'd11: p = 7'd36;
            4'd4, 4'd10: p = 7'd44;
            4'd5, 4'd9:  p = 7'd52;
            4'd6, 4'd8:  p = 7'd58;
            4'd7:        p = 7'd64;
            default:     p = 7'd0;
        endcase
        return p;
    endfunction

    // History age shown on each bar: centre bar newest, then alternating out.
    function automatic logic [3:0] bar_age(input logic [3:0] bar);
        logic [3:0] a;
        case (bar)
            4'd0:    a = 4'd13;
            4'd1:    a = 4'd11;
            4'd2:    a = 4'd9;
            4'd3:    a = 4'd7;
            4'd4:    a = 4'd5;
            4'd5:    a = 4'd3;
            4'd6:    a = 4'd1;
            4'd7:    a = 4'd0;
            4'd8:    a = 4'd2;
            4'd9:    a = 4'd4;
            4'd10:   a = 4'd6;
            4'd11:   a = 4'd8;
            4'd12:   a = 4'd10;
            4'd13:   a = 4'd12;
            default: a = 4'd14;
        endcase
        return a;
    endfunction

endpackage

@@ rtl/lhbm_ifs.sv @@
// Channel interfaces of the level history bar meter: input items, bar results
// and configuration writes. Depends on nothing.

interface lhbm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  speech_mode;
    logic [7:0]  loudness;
    logic [47:0] now_time;
    logic        force_refresh;

    modport source (output valid, speech_mode, loudness, now_time, force_refresh,
                    input ready);
    modport sink   (input valid, speech_mode, loudness, now_time, force_refresh,
                    output ready);
endinterface

interface lhbm_out_if;
    logic              valid;
    logic              ready;
    logic [3:0]        bar_index;
    logic [6:0]        bar_height;
    logic signed [10:0] bar_top;
    logic              last_update;

    modport source (output valid, bar_index, bar_height, bar_top, last_update,
                    input ready);
    modport sink   (input valid, bar_index, bar_height, bar_top, last_update,
                    output ready);
endinterface

interface lhbm_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [19:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/lhbm_cfg_regs.sv @@
// Configuration register file of the level history bar meter.
// Depends on lhbm_pkg.
module lhbm_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_index,
    input  logic [19:0]       i_data,
    output lhbm_pkg::t_cfg    o_cfg
);

    lhbm_pkg::t_cfg r_cfg;

    // Writes are always taken.
    assign o_ready = 1'b1;
    assign o_cfg   = r_cfg;

    // Register write decode; data is truncated to each register's width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.update_interval <= lhbm_pkg::RST_UPDATE_INTERVAL;
            r_cfg.center_line     <= lhbm_pkg::RST_CENTER_LINE;
            r_cfg.min_height      <= lhbm_pkg::RST_MIN_HEIGHT;
            r_cfg.deadband        <= lhbm_pkg::RST_DEADBAND;
        end else if (i_valid) begin
            unique case (i_index)
                lhbm_pkg::CFG_UPDATE_INTERVAL: r_cfg.update_interval <= i_data;
                lhbm_pkg::CFG_CENTER_LINE:     r_cfg.center_line     <= i_data[9:0];
                lhbm_pkg::CFG_MIN_HEIGHT:      r_cfg.min_height      <= i_data[5:0];
                lhbm_pkg::CFG_DEADBAND:        r_cfg.deadband        <= i_data[5:0];
                default: begin
                end
            endcase
        end
    end

endmodule

@@ rtl/lhbm_ctrl.sv @@
// Controller of the level history bar meter: takes items, walks the bar
// counter and closes each refresh. Depends on lhbm_pkg.
module lhbm_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  lhbm_pkg::t_status    i_status,
    output lhbm_pkg::t_cmd       o_cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CALC  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0] r_state, n_state;
    logic [3:0] r_bar, n_bar;

    assign o_in_ready = (r_state == ST_IDLE);

    // Next state and command decode.
    always_comb begin
        n_state     = r_state;
        n_bar       = r_bar;
        o_cmd       = '0;
        o_cmd.bar   = r_bar;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_status.is_hidden) begin
                        o_cmd.clear = 1'b1;
                    end else if (!i_status.is_early) begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_CALC;
                        n_bar       = '0;
                    end
                end
            end
            ST_CALC: begin
                o_cmd.step = 1'b1;
                if (i_status.can_step) begin
                    if (r_bar == lhbm_pkg::LAST_BAR) begin
                        n_state = ST_FLUSH;
                    end else begin
                        n_bar = r_bar + 4'd1;
                    end
                end
            end
            ST_FLUSH: begin
                o_cmd.flush = 1'b1;
                if (i_status.flush_ok) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_bar   <= '0;
        end else begin
            r_state <= n_state;
            r_bar   <= n_bar;
        end
    end

endmodule

@@ rtl/lhbm_dp.sv @@
// Datapath of the level history bar meter: history line, shown heights,
// update time, bar height unit and the held and output result registers.
// Depends on lhbm_pkg.
module lhbm_dp #(
    parameter int BAR_COUNT = lhbm_pkg::BAR_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lhbm_pkg::t_cfg        i_cfg,
    input  lhbm_pkg::t_cmd        i_cmd,
    output lhbm_pkg::t_status     o_status,
    input  logic [1:0]            i_speech_mode,
    input  logic [7:0]            i_loudness,
    input  logic [47:0]           i_now_time,
    input  logic                  i_force_refresh,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [3:0]            o_bar_index,
    output logic [6:0]            o_bar_height,
    output logic signed [10:0]    o_bar_top,
    output logic                  o_last_update
);

    localparam logic [3:0] BarLimit = 4'(BAR_COUNT);

    logic [7:0]  r_hist  [lhbm_pkg::DEPTH];
    logic [6:0]  r_shown [lhbm_pkg::DEPTH];
    logic [47:0] r_next;
    logic [1:0]  r_vstate;
    logic        r_force;

    logic        r_pend_valid;
    logic [3:0]  r_pend_index;
    logic [6:0]  r_pend_height;
    logic [10:0] r_pend_top;

    logic        r_out_valid;
    logic [3:0]  r_out_index;
    logic [6:0]  r_out_height;
    logic [10:0] r_out_top;
    logic        r_out_last;

    logic [6:0]  peak, range_w, height, prev, delta;
    logic [3:0]  age;
    logic [7:0]  sample;
    logic [14:0] prod;
    logic [15:0] num, qsum;
    logic [6:0]  quot;
    logic [10:0] top;
    logic        emit, out_free, can_step, flush_ok, step_go, push_pend, flush_go;

    // Bar range: peak above the floor, or zero when the floor reaches the peak.
    always_comb begin
        peak    = lhbm_pkg::bar_peak(i_cmd.bar);
        range_w = (peak > {1'b0, i_cfg.min_height}) ? peak - {1'b0, i_cfg.min_height}
                                                     : 7'd0;
        age     = lhbm_pkg::bar_age(i_cmd.bar);
        sample  = r_hist[age];
        prod    = 15'(sample) * 15'(range_w);
        num     = 16'(prod) + 16'd127;
        // Division by 255, exact for the numerator range used here.
        qsum    = num + (num >> 8) + 16'd1;
        quot    = qsum[14:8];
    end

    // Height of the selected bar in the latched voice state.
    always_comb begin
        case (r_vstate)
            lhbm_pkg::VS_PREPARING: height = {1'b0, i_cfg.min_height} + (range_w >> 3);
            lhbm_pkg::VS_LISTENING: height = (i_cmd.bar < BarLimit)
                                             ? {1'b0, i_cfg.min_height} + quot
                                             : {1'b0, i_cfg.min_height};
            default:                height = {1'b0, i_cfg.min_height};
        endcase
    end

    // Change against the shown height and the top coordinate.
    always_comb begin
        prev  = r_shown[i_cmd.bar];
        delta = (prev > height) ? prev - height : height - prev;
        emit  = (r_force || (delta >= {1'b0, i_cfg.deadband})) && (i_cmd.bar < BarLimit);
        top   = {1'b0, i_cfg.center_line} - {5'd0, height[6:1]};
    end

    // Handshake of the held result and the output register.
    always_comb begin
        out_free  = !r_out_valid || i_out_ready;
        can_step  = !emit || !r_pend_valid || out_free;
        flush_ok  = !r_pend_valid || out_free;
        step_go   = i_cmd.step && can_step;
        push_pend = step_go && emit && r_pend_valid;
        flush_go  = i_cmd.flush && flush_ok && r_pend_valid;
    end

    assign o_status.is_hidden = (i_speech_mode == lhbm_pkg::VS_HIDDEN);
    assign o_status.is_early  = !i_force_refresh && (i_now_time < r_next);
    assign o_status.can_step  = can_step;
    assign o_status.flush_ok  = flush_ok;

    // Architectural state and result control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < lhbm_pkg::DEPTH; i++) begin
                r_hist[i]  <= '0;
                r_shown[i] <= '0;
            end
            r_next       <= '0;
            r_vstate     <= lhbm_pkg::VS_HIDDEN;
            r_force      <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                for (int i = 0; i < lhbm_pkg::DEPTH; i++) begin
                    r_hist[i] <= '0;
                end
                r_next <= '0;
            end
            if (i_cmd.start) begin
                r_vstate <= i_speech_mode;
                r_force  <= i_force_refresh;
                r_next   <= i_now_time + {28'd0, i_cfg.update_interval};
                if (i_speech_mode == lhbm_pkg::VS_LISTENING) begin
                    for (int i = lhbm_pkg::DEPTH - 1; i > 0; i--) begin
                        r_hist[i] <= r_hist[i - 1];
                    end
                    r_hist[0] <= i_loudness;
                end
            end
            if (step_go) begin
                r_shown[i_cmd.bar] <= height;
                if (emit) begin
                    r_pend_valid <= 1'b1;
                end
            end
            if (push_pend || flush_go) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (flush_go) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    // Result payloads.
    always_ff @(posedge i_clk) begin
        if (step_go && emit) begin
            r_pend_index  <= i_cmd.bar;
            r_pend_height <= height;
            r_pend_top    <= top;
        end
        if (push_pend || flush_go) begin
            r_out_index  <= r_pend_index;
            r_out_height <= r_pend_height;
            r_out_top    <= r_pend_top;
            r_out_last   <= flush_go;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_bar_index   = r_out_index;
    assign o_bar_height  = r_out_height;
    assign o_bar_top     = $signed(r_out_top);
    assign o_last_update = r_out_last;

endmodule

@@ rtl/level_history_bar_meter.sv @@
// Level history bar meter top level. A refreshing item starts a refresh; the
// bar counter then walks the 15 bars and the final result is released, and only
// then is the next item taken. Output stalls can hold the walk. Hidden and early
// items are taken at one per cycle. Results leave through an output register.
// Reset is synchronous, active low, and clears history, shown heights, update
// time and loads the register defaults.
module level_history_bar_meter #(
    parameter int BAR_COUNT = lhbm_pkg::BAR_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lhbm_in_if.sink     i_in,
    lhbm_out_if.source  o_out,
    lhbm_cfg_if.sink    i_cfg
);

    lhbm_pkg::t_cfg    cfg;
    lhbm_pkg::t_cmd    cmd;
    lhbm_pkg::t_status status;
    logic              in_ready;
    logic              cfg_ready;

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = cfg_ready;

    // Configuration registers.
    lhbm_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg.valid),
        .o_ready (cfg_ready),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (cfg)
    );

    // Sequencer.
    lhbm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Bar datapath.
    lhbm_dp #(
        .BAR_COUNT (BAR_COUNT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_speech_mode   (i_in.speech_mode),
        .i_loudness      (i_in.loudness),
        .i_now_time      (i_in.now_time),
        .i_force_refresh (i_in.force_refresh),
        .o_out_valid     (o_out.valid),
        .i_out_ready     (o_out.ready),
        .o_bar_index     (o_out.bar_index),
        .o_bar_height    (o_out.bar_height),
        .o_bar_top       (o_out.bar_top),
        .o_last_update   (o_out.last_update)
    );

endmodule

@@ rtl/lhbm_checker.sv @@
// Port-level checker for the level history bar meter and its bind statement.
// Depends on lhbm_pkg and the top level's ports.
module lhbm_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic [1:0]        i_speech_mode,
    input logic              i_force_refresh,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [3:0]        i_bar_index,
    input logic [6:0]        i_bar_height,
    input logic signed [10:0] i_bar_top,
    input logic              i_last_update
);

    logic in_txn;
    assign in_txn = i_in_valid && i_in_ready;

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_bar_index)
            && $stable(i_bar_height) && $stable(i_bar_top) && $stable(i_last_update))
        else $error("result changed while stalled");

    // Bar number and height stay within the display.
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_bar_index <= lhbm_pkg::LAST_BAR) && (i_bar_height <= 7'd64))
        else $error("result outside the display range");

    // While a non-final result waits, the item is still being worked on.
    a_busy_mid_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_last_update |-> !i_in_ready)
        else $error("new item taken before the final result of the previous one");

    // A forced visible transaction always starts a refresh.
    a_forced_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_txn && (i_speech_mode != lhbm_pkg::VS_HIDDEN) && i_force_refresh
            |=> !i_in_ready)
        else $error("forced item did not start a refresh");

    // A hidden-state transaction finishes at once.
    a_hidden_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_txn && (i_speech_mode == lhbm_pkg::VS_HIDDEN) |=> i_in_ready)
        else $error("hidden item kept the block busy");

endmodule

bind level_history_bar_meter lhbm_checker u_lhbm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_speech_mode   (i_in.speech_mode),
    .i_force_refresh (i_in.force_refresh),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_bar_index     (o_out.bar_index),
    .i_bar_height    (o_out.bar_height),
    .i_bar_top       (o_out.bar_top),
    .i_last_update   (o_out.last_update)
);

@@ test/level_history_bar_meter_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the level history bar meter: directed rows, then
// random phases under several register settings.
// Depends on lhbm_pkg, the lhbm channel interfaces and the RTL.
module level_history_bar_meter_test;

    localparam int METER_BARS  = lhbm_pkg::BAR_COUNT_DEF;
    localparam int HALF_PERIOD = 5;
    localparam int SETTLE      = 24;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 2000;
    localparam int PHASE_ITEMS = 65;

    localparam int unsigned PEAK_OF_BAR [15] = '{18, 22, 28, 36, 44, 52, 58, 64,
                                                 58, 52, 44, 36, 28, 22, 18};
    localparam int unsigned BAR_OF_AGE  [15] = '{7, 6, 8, 5, 9, 4, 10, 3,
                                                 11, 2, 12, 1, 13, 0, 14};

    typedef struct packed {
        logic [1:0]  state;
        logic [7:0]  loudness;
        logic [47:0] stamp;
        logic        forced;
    } t_meter_item;

    typedef struct packed {
        logic [3:0]  bar;
        logic [6:0]  height;
        logic [10:0] top;
        logic        last;
    } t_bar_update;

    typedef struct packed {
        logic [19:0] interval;
        logic [19:0] centre;
        logic [19:0] floor_h;
        logic [19:0] band;
    } t_meter_settings;

    typedef enum logic {ROW_ITEM, ROW_REG} t_row_kind;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ALL} t_row_check;

    typedef struct packed {
        t_row_kind   kind;
        logic [1:0]  state;
        logic [7:0]  loudness;
        logic [47:0] stamp;
        logic        forced;
        t_row_check  chk;
        logic [6:0]  all_h;
        logic [1:0]  reg_idx;
        logic [19:0] reg_val;
    } t_stim_row;

    // Directed rows. CHK_ALL means every bar is expected at the typed height.
    localparam t_stim_row DIRECTED_ROWS [23] = '{
        '{ROW_ITEM, lhbm_pkg::VS_OTHER, 8'd0, 48'd0,
          1'b0, CHK_ALL, 7'd6, lhbm_pkg::CFG_UPDATE_INTERVAL, 20'd0},
        '{ROW_ITEM, lhbm_pkg::VS_OTHER, 8'd0, 48'd100,
          1'b0, CHK_NONE, 7'd0, lhbm_pkg::CFG_UPDATE_INTERVAL, 20'd0},
        '{ROW_ITEM, lhbm_pkg::VS_OTHER, 8'd0, 48'd100,
          1'b1, CHK_ALL, 7'd6, lhbm_pkg::CFG_UPDATE_INTERVAL, 20'd0},
        '{ROW_ITEM, lhbm_pkg::VS_LISTENING, 8'd255, 48'd200000,
          1'b0, CHK_MODEL, 7'd0, lhbm_pkg::CFG_UPDATE_INTERVAL, 20'd0},
        '{ROW_ITEM, lhbm_pkg::VS_LISTENING, 8'd128, 48'd300000,
          1'b0, CHK_MODEL, 7'd0, lhbm_pkg::CFG_UPDATE_INTERVAL, 20'd0},
        '{ROW_ITEM, lhbm_pkg::VS_PREPARING, 8'd77, 48'd300001,
          1'b1, CHK_MODEL, 7'd0, lhbm_pkg::CFG_UPDATE_INTERVAL, 20'd0},
        '{ROW_ITEM, lhbm_pkg::VS_HIDDEN, 8'd255, 48'hFFFF_FFFF_FFFF,
          1'b1, CHK_NONE, 7'd0, lhbm_pkg::CFG_UPDATE_INTERVAL, 20'd0},
        '{ROW_ITEM, lhbm_pkg::VS_LISTENING, 8'd0, 48'd0,
          1'b0, CHK_MODEL, 7'd0, lhbm_pkg::CFG_UPDATE_INTERVAL, 20'd0},
        '{ROW_ITEM, lhbm_pkg::VS_LISTENING, 8'd0, 48'd0,
          1'b1, CHK_ALL, 7'd6, lhbm_pkg::CFG_UPDATE_INTERVAL, 20'd0},
        '{ROW_ITEM, lhbm_pkg::VS_LISTENING, 8'd255, 48'd1,
          1'b1, CHK_MODEL, 7'd0, lhbm_pkg::CFG_UPDATE_INTERVAL, 20'd0},
        '{ROW_ITEM, lhbm_pkg::VS_LISTENING, 8'd255, 48'd2,
          1'b1, CHK_MODEL, 7'd0, lhbm_pkg::CFG_UPDATE_INTERVAL, 20'd0},
        '{ROW_ITEM, lhbm_pkg::VS_LISTENING, 8'd255, 48'd3,
          1'b1, CHK_MODEL, 7'd0, lhbm_pkg::CFG_UPDATE_INTERVAL, 20'd0},
        '{ROW_ITEM, lhbm_pkg::VS_LISTENING, 8'd255, 48'd4,
          1'b1, CHK_MODEL, 7'd0, lhbm_pkg::CFG_UPDATE_INTERVAL, 20'd0},
        '{ROW_ITEM, lhbm_pkg::VS_LISTENING, 8'd200, 48'hFFFF_FFFF_FFFF,
          1'b0, CHK_MODEL, 7'd0, lhbm_pkg::CFG_UPDATE_INTERVAL, 20'd0},
        '{ROW_ITEM, lhbm_pkg::VS_LISTENING, 8'd1, 48'd65998,
          1'b0, CHK_NONE, 7'd0, lhbm_pkg::CFG_UPDATE_INTERVAL, 20'd0},
        '{ROW_ITEM, lhbm_pkg::VS_LISTENING, 8'd1, 48'd65999,
          1'b0, CHK_MODEL, 7'd0, lhbm_pkg::CFG_UPDATE_INTERVAL, 20'd0},
        '{ROW_ITEM, lhbm_pkg::VS_LISTENING, 8'd1, 48'd131998,
          1'b0, CHK_NONE, 7'd0, lhbm_pkg::CFG_UPDATE_INTERVAL, 20'd0},
        '{ROW_ITEM, lhbm_pkg::VS_LISTENING, 8'd255, 48'hAAAA_5555_AAAA,
          1'b0, CHK_MODEL, 7'd0, lhbm_pkg::CFG_UPDATE_INTERVAL, 20'd0},
        '{ROW_REG, lhbm_pkg::VS_HIDDEN, 8'd0, 48'd0,
          1'b0, CHK_NONE, 7'd0, lhbm_pkg::CFG_MIN_HEIGHT, 20'd63},
        '{ROW_REG, lhbm_pkg::VS_HIDDEN, 8'd0, 48'd0,
          1'b0, CHK_NONE, 7'd0, lhbm_pkg::CFG_DEADBAND, 20'd0},
        '{ROW_ITEM, lhbm_pkg::VS_OTHER, 8'd0, 48'd0,
          1'b1, CHK_ALL, 7'd63, lhbm_pkg::CFG_UPDATE_INTERVAL, 20'd0},
        '{ROW_ITEM, lhbm_pkg::VS_PREPARING, 8'd0, 48'd0,
          1'b1, CHK_ALL, 7'd63, lhbm_pkg::CFG_UPDATE_INTERVAL, 20'd0},
        '{ROW_ITEM, lhbm_pkg::VS_LISTENING, 8'd255, 48'h5555_AAAA_5555,
          1'b0, CHK_MODEL, 7'd0, lhbm_pkg::CFG_UPDATE_INTERVAL, 20'd0}
    };

    logic i_clk;
    logic i_rst_n;

    lhbm_in_if  sample_ch ();
    lhbm_out_if bar_ch ();
    lhbm_cfg_if reg_ch ();

    level_history_bar_meter #(
        .BAR_COUNT(METER_BARS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (sample_ch),
        .o_out   (bar_ch),
        .i_cfg   (reg_ch)
    );

    // Predictor state and register copies.
    logic [7:0]  hist_samples [15];
    logic [6:0]  drawn_height [15];
    logic [47:0] due_time;
    logic [19:0] cfg_interval;
    logic [9:0]  cfg_centre;
    logic [5:0]  cfg_floor;
    logic [5:0]  cfg_deadband;

    t_bar_update fresh_updates [$];
    t_bar_update bar_updates_due [$];

    int mismatch_count;
    int src_idle_pct;
    int sink_idle_pct;
    int hold_requests;

    // Clock.
    initial i_clk = 1'b0;
    always #(HALF_PERIOD) i_clk = ~i_clk;

    task automatic flag_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // Usable height range of a bar above the floor; zero when the peak does not lie above it.
    function automatic int unsigned bar_span(input int unsigned b);
        return (PEAK_OF_BAR[b] > cfg_floor) ? PEAK_OF_BAR[b] - cfg_floor : 0;
    endfunction

    // Works out the bar updates that one accepted item causes and advances the state.
    function automatic void meter_refresh(input t_meter_item it);
        int unsigned hts [15];
        int unsigned dlt;
        int unsigned b;
        int unsigned a;
        t_bar_update upd;
        fresh_updates.delete();
        if (it.state == lhbm_pkg::VS_HIDDEN) begin
            for (a = 0; a < 15; a++) hist_samples[a] = 8'd0;
            due_time = 48'd0;
            return;
        end
        if (!it.forced && it.stamp < due_time) return;

        if (it.state == lhbm_pkg::VS_LISTENING) begin
            for (a = 14; a > 0; a--) hist_samples[a] = hist_samples[a - 1];
            hist_samples[0] = it.loudness;
        end

        for (b = 0; b < 15; b++) hts[b] = cfg_floor;
        if (it.state == lhbm_pkg::VS_PREPARING) begin
            for (b = 0; b < 15; b++) hts[b] = cfg_floor + bar_span(b) / 8;
        end else if (it.state == lhbm_pkg::VS_LISTENING) begin
            // Newest sample on the centre bar, older ones alternating outwards.
            for (a = 0; a < 15; a++) begin
                b = BAR_OF_AGE[a];
                if (b < METER_BARS) begin
                    hts[b] = cfg_floor + (hist_samples[a] * bar_span(b) + 127) / 255;
                end
            end
        end

        // Only bars that moved by at least the deadband are sent, unless forced.
        for (b = 0; b < METER_BARS; b++) begin
            dlt = (drawn_height[b] > hts[b]) ? drawn_height[b] - hts[b]
                                             : hts[b] - drawn_height[b];
            if (it.forced || dlt >= cfg_deadband) begin
                upd.bar    = 4'(b);
                upd.height = 7'(hts[b]);
                upd.top    = {1'b0, cfg_centre} - 11'(hts[b] >> 1);
                upd.last   = 1'b0;
                fresh_updates.push_back(upd);
            end
        end
        if (fresh_updates.size() > 0) fresh_updates[fresh_updates.size() - 1].last = 1'b1;

        for (b = 0; b < 15; b++) drawn_height[b] = 7'(hts[b]);
        due_time = it.stamp + {28'd0, cfg_interval};
    endfunction

    // Offers one item, waits for its transaction and records what it should cause.
    task automatic offer_item(input t_meter_item it, input t_row_check chk,
                              input logic [6:0] all_h);
        t_bar_update upd;
        int b;
        if ($urandom_range(99) < src_idle_pct) begin
            sample_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        sample_ch.valid         <= 1'b1;
        sample_ch.speech_mode   <= it.state;
        sample_ch.loudness      <= it.loudness;
        sample_ch.now_time      <= it.stamp;
        sample_ch.force_refresh <= it.forced;
        do @(posedge i_clk); while (!sample_ch.ready);
        meter_refresh(it);
        case (chk)
            CHK_MODEL: begin
                foreach (fresh_updates[i]) bar_updates_due.push_back(fresh_updates[i]);
            end
            CHK_ALL: begin
                for (b = 0; b < METER_BARS; b++) begin
                    upd.bar    = 4'(b);
                    upd.height = all_h;
                    upd.top    = {1'b0, cfg_centre} - 11'(all_h >> 1);
                    upd.last   = (b == METER_BARS - 1);
                    bar_updates_due.push_back(upd);
                end
            end
            default: begin
            end
        endcase
    endtask

    // Leaves the write valid high so that back-to-back writes need no lowering.
    task automatic put_register(input logic [1:0] idx, input logic [19:0] val);
        reg_ch.valid <= 1'b1;
        reg_ch.index <= idx;
        reg_ch.data  <= val;
        do @(posedge i_clk); while (!reg_ch.ready);
        case (idx)
            lhbm_pkg::CFG_UPDATE_INTERVAL: cfg_interval = val;
            lhbm_pkg::CFG_CENTER_LINE:     cfg_centre   = val[9:0];
            lhbm_pkg::CFG_MIN_HEIGHT:      cfg_floor    = val[5:0];
            lhbm_pkg::CFG_DEADBAND:        cfg_deadband = val[5:0];
            default: begin
            end
        endcase
    endtask

    // Stops offering, waits for every expected update, then lets the block go idle.
    task automatic drain_block();
        sample_ch.valid <= 1'b0;
        while (bar_updates_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Mostly listening items on time, with early, forced, hidden and wrapping ones mixed in.
    function automatic t_meter_item random_item();
        t_meter_item it;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 62) it.state = lhbm_pkg::VS_LISTENING;
        else if (pick < 76) it.state = lhbm_pkg::VS_PREPARING;
        else if (pick < 91) it.state = lhbm_pkg::VS_OTHER;
        else it.state = lhbm_pkg::VS_HIDDEN;
        it.loudness = 8'($urandom);
        it.forced   = ($urandom_range(99) < 12);
        pick = $urandom_range(99);
        if (pick < 5) it.stamp = 48'({$urandom, $urandom});
        else if (pick < 9) it.stamp = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(cfg_interval));
        else if (pick < 22) it.stamp = due_time - 48'd1 - 48'($urandom_range(3));
        else it.stamp = due_time + 48'($urandom_range(cfg_interval / 4));
        return it;
    endfunction

    // Checks each bar update transaction against the oldest expectation.
    always @(posedge i_clk) begin : bar_checker
        t_bar_update want;
        if (i_rst_n && bar_ch.valid && bar_ch.ready) begin
            if (bar_updates_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected update for bar %0d", bar_ch.bar_index));
            end else begin
                want = bar_updates_due.pop_front();
                if (bar_ch.bar_index !== want.bar)
                    flag_mismatch($sformatf("bar index %0d, want %0d",
                                            bar_ch.bar_index, want.bar));
                if (bar_ch.bar_height !== want.height)
                    flag_mismatch($sformatf("bar %0d height %0d, want %0d",
                                            want.bar, bar_ch.bar_height, want.height));
                if (bar_ch.bar_top !== want.top)
                    flag_mismatch($sformatf("bar %0d top %0d, want %0d",
                                            want.bar, bar_ch.bar_top, $signed(want.top)));
                if (bar_ch.last_update !== want.last)
                    flag_mismatch($sformatf("bar %0d last flag %0b, want %0b",
                                            want.bar, bar_ch.last_update, want.last));
            end
        end
    end

    // Result receiver: random stalls, plus a long hold-off on request.
    initial begin : bar_receiver
        int hold_left;
        int served;
        hold_left = 0;
        served    = 0;
        bar_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_requests != served) begin
                served    = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                bar_ch.ready <= 1'b0;
            end else begin
                bar_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Watchdog: ends the run when no transaction happens on any channel for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((sample_ch.valid && sample_ch.ready) || (bar_ch.valid && bar_ch.ready) ||
                (reg_ch.valid && reg_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("level_history_bar_meter test failed");
        $finish;
    end

    // Main sequence.
    initial begin : stimulus
        int r;
        int ph;
        int n;
        t_meter_item it;
        t_meter_settings st;

        mismatch_count = 0;
        hold_requests  = 0;
        src_idle_pct   = 11;
        sink_idle_pct  = 79;
        for (r = 0; r < 15; r++) begin
            hist_samples[r] = 8'd0;
            drawn_height[r] = 7'd0;
        end
        due_time     = 48'd0;
        cfg_interval = lhbm_pkg::RST_UPDATE_INTERVAL;
        cfg_centre   = lhbm_pkg::RST_CENTER_LINE;
        cfg_floor    = lhbm_pkg::RST_MIN_HEIGHT;
        cfg_deadband = lhbm_pkg::RST_DEADBAND;

        i_rst_n                 <= 1'b0;
        sample_ch.valid         <= 1'b0;
        sample_ch.speech_mode   <= lhbm_pkg::VS_HIDDEN;
        sample_ch.loudness      <= 8'd0;
        sample_ch.now_time      <= 48'd0;
        sample_ch.force_refresh <= 1'b0;
        reg_ch.valid            <= 1'b0;
        reg_ch.index            <= lhbm_pkg::CFG_UPDATE_INTERVAL;
        reg_ch.data             <= 20'd0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows from reset values.
        for (r = 0; r < $size(DIRECTED_ROWS); r++) begin
            if (DIRECTED_ROWS[r].kind == ROW_REG) begin
                if (r > 0 && DIRECTED_ROWS[r - 1].kind == ROW_ITEM) drain_block();
                put_register(DIRECTED_ROWS[r].reg_idx, DIRECTED_ROWS[r].reg_val);
            end else begin
                reg_ch.valid <= 1'b0;
                it.state    = DIRECTED_ROWS[r].state;
                it.loudness = DIRECTED_ROWS[r].loudness;
                it.stamp    = DIRECTED_ROWS[r].stamp;
                it.forced   = DIRECTED_ROWS[r].forced;
                offer_item(it, DIRECTED_ROWS[r].chk, DIRECTED_ROWS[r].all_h);
            end
        end

        // Random phases, each under its own register setting and idling mix.
        for (ph = 0; ph < 6; ph++) begin
            drain_block();
            src_idle_pct  = (ph < 2) ? 11 : (ph < 4) ? 79 : 0;
            sink_idle_pct = (ph < 2) ? 79 : (ph < 4) ? 11 : 0;
            case (ph)
                0: st = '{20'd66000, 20'd354, 20'd6, 20'd2};
                1: st = '{20'd0, 20'd0, 20'd0, 20'd0};
                2: st = '{20'hFFFFF, 20'd1023, 20'd63, 20'd63};
                3: st = '{20'd1000, 20'd512, 20'd20, 20'd1};
                default: st = '{20'($urandom), 20'($urandom), 20'($urandom), 20'($urandom)};
            endcase
            put_register(lhbm_pkg::CFG_UPDATE_INTERVAL, st.interval);
            put_register(lhbm_pkg::CFG_CENTER_LINE, st.centre);
            put_register(lhbm_pkg::CFG_MIN_HEIGHT, st.floor_h);
            put_register(lhbm_pkg::CFG_DEADBAND, st.band);
            reg_ch.valid <= 1'b0;
            // Long receiver hold-off so that the block backs up onto its input.
            if (ph == 0) hold_requests++;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 2 && n == PHASE_ITEMS / 2) drain_block();
                offer_item(random_item(), CHK_MODEL, 7'd0);
            end
        end
        drain_block();

        if (mismatch_count == 0) begin
            $display("level_history_bar_meter test passed");
        end else begin
            $display("level_history_bar_meter test failed");
        end
        $finish;
    end

endmodule

@@ level_history_bar_meter.f @@
rtl/lhbm_pkg.sv
rtl/lhbm_ifs.sv
rtl/lhbm_cfg_regs.sv
rtl/lhbm_ctrl.sv
rtl/lhbm_dp.sv
rtl/level_history_bar_meter.sv
rtl/lhbm_checker.sv
test/level_history_bar_meter_test.sv
